// File: rtl/smd_pkg.sv
// smd_pkg: shared types and constants of the six-channel signed motor drive
// no dependencies; imported by smd_chan and six_channel_signed_motor_drive

package smd_pkg;

    localparam int CHANNELS    = 6;
    localparam int BANK_CHANS  = 4;
    localparam int SPEED_W     = 16;
    localparam int MAG_W       = SPEED_W - 1;
    localparam int PERIOD_W    = 16;
    localparam int DUTY_W      = 16;
    localparam int PROD_W      = MAG_W + PERIOD_W;

    // command value that means stop besides zero
    localparam logic [SPEED_W-1:0]  STOP_CODE    = 16'h8000;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'h7000;

    // forward and reverse masks of channels 0..3 within drive bank a
    localparam logic [7:0] BANK_FWD [BANK_CHANS] = '{8'h02, 8'h04, 8'h20, 8'h40};
    localparam logic [7:0] BANK_REV [BANK_CHANS] = '{8'h01, 8'h08, 8'h10, 8'h80};

    // channel 4 and channel 5 direction pairs
    localparam logic [1:0] CH4_FWD = 2'b10;
    localparam logic [1:0] CH4_REV = 2'b01;
    localparam logic [1:0] CH5_FWD = 2'b01;
    localparam logic [1:0] CH5_REV = 2'b10;

    typedef enum logic [1:0] {
        DIR_STOP,
        DIR_FWD,
        DIR_REV
    } t_dir;

    typedef struct packed {
        t_dir               dir;
        logic [DUTY_W-1:0]  duty;
    } t_chan_res;

endpackage

// File: rtl/smd_chan.sv
// smd_chan: decode of one signed speed command into direction and pwm duty
// depends on smd_pkg

module smd_chan
    import smd_pkg::*;
(
    input  logic [SPEED_W-1:0]  i_speed,
    input  logic [PERIOD_W-1:0] i_period,
    output t_chan_res           o_res
);

    logic              stop;
    logic              neg;
    logic [SPEED_W-1:0] neg_speed;
    logic [MAG_W-1:0]  mag;
    logic [PROD_W-1:0] prod;

    // stop on zero or the most negative code
    assign stop      = (i_speed == '0) || (i_speed == STOP_CODE);
    assign neg       = i_speed[SPEED_W-1];
    assign neg_speed = SPEED_W'(~i_speed + 1'b1);

    // magnitude fits in 15 bits once the stop code is excluded
    always_comb begin
        if (stop) begin
            mag = '0;
        end else if (neg) begin
            mag = neg_speed[MAG_W-1:0];
        end else begin
            mag = i_speed[MAG_W-1:0];
        end
    end

    // duty = magnitude * period / 32768, truncated
    assign prod = PROD_W'(mag) * PROD_W'(i_period);

    always_comb begin
        o_res.duty = prod[PROD_W-1:MAG_W];
        if (stop) begin
            o_res.dir = DIR_STOP;
        end else if (neg) begin
            o_res.dir = DIR_REV;
        end else begin
            o_res.dir = DIR_FWD;
        end
    end

endmodule

// File: rtl/six_channel_signed_motor_drive.sv
// six_channel_signed_motor_drive: top level, six speed commands to h-bridge bits and duty
// depends on smd_pkg and smd_chan
//
//  channel   handshake                      payload
//  command   start in, busy out             i_speed_ch0 .. i_speed_ch5
//  result    o_valid strobe, one cycle      o_drive_bank_a, o_drive_ch4/5, o_duty_ch0..5
//  config    i_cfg_valid in, o_cfg_ready    i_cfg_data (pwm period)
//
//  a request enters an input register, the six per-channel multipliers run in
//  the next cycle and the result register captures what they compute.
//  one request is taken every cycle; busy is never raised.
//  synchronous active-low reset clears the valid bits and loads period 0x7000.
//  the receiver cannot stall: each result is shown for exactly one cycle.

module six_channel_signed_motor_drive
    import smd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [SPEED_W-1:0]  i_speed_ch0,
    input  logic [SPEED_W-1:0]  i_speed_ch1,
    input  logic [SPEED_W-1:0]  i_speed_ch2,
    input  logic [SPEED_W-1:0]  i_speed_ch3,
    input  logic [SPEED_W-1:0]  i_speed_ch4,
    input  logic [SPEED_W-1:0]  i_speed_ch5,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [PERIOD_W-1:0] i_cfg_data,
    output logic                o_valid,
    output logic [7:0]          o_drive_bank_a,
    output logic [1:0]          o_drive_ch4,
    output logic [1:0]          o_drive_ch5,
    output logic [DUTY_W-1:0]   o_duty_ch0,
    output logic [DUTY_W-1:0]   o_duty_ch1,
    output logic [DUTY_W-1:0]   o_duty_ch2,
    output logic [DUTY_W-1:0]   o_duty_ch3,
    output logic [DUTY_W-1:0]   o_duty_ch4,
    output logic [DUTY_W-1:0]   o_duty_ch5
);

    logic [PERIOD_W-1:0] r_pwm_period;
    logic                r_in_valid;
    logic [SPEED_W-1:0]  r_speed [CHANNELS];
    logic                r_out_valid;
    logic [7:0]          r_bank;
    logic [1:0]          r_d4;
    logic [1:0]          r_d5;
    logic [DUTY_W-1:0]   r_duty [CHANNELS];

    logic [7:0]          n_bank;
    logic [1:0]          n_d4;
    logic [1:0]          n_d5;
    t_chan_res           chan_res [CHANNELS];

    // always ready for a request and for a config write
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // period register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_period <= PERIOD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_pwm_period <= i_cfg_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_speed[0] <= i_speed_ch0;
            r_speed[1] <= i_speed_ch1;
            r_speed[2] <= i_speed_ch2;
            r_speed[3] <= i_speed_ch3;
            r_speed[4] <= i_speed_ch4;
            r_speed[5] <= i_speed_ch5;
        end
    end

    // one decode and multiplier lane per channel
    for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
        smd_chan u_chan (
            .i_speed  (r_speed[g]),
            .i_period (r_pwm_period),
            .o_res    (chan_res[g])
        );
    end

    // pack direction bits
    always_comb begin
        n_bank = '0;
        for (int i = 0; i < BANK_CHANS; i++) begin
            unique case (chan_res[i].dir)
                DIR_FWD: n_bank = n_bank | BANK_FWD[i];
                DIR_REV: n_bank = n_bank | BANK_REV[i];
                default: n_bank = n_bank;
            endcase
        end
        unique case (chan_res[4].dir)
            DIR_FWD: n_d4 = CH4_FWD;
            DIR_REV: n_d4 = CH4_REV;
            default: n_d4 = '0;
        endcase
        unique case (chan_res[5].dir)
            DIR_FWD: n_d5 = CH5_FWD;
            DIR_REV: n_d5 = CH5_REV;
            default: n_d5 = '0;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_bank <= n_bank;
            r_d4   <= n_d4;
            r_d5   <= n_d5;
            for (int i = 0; i < CHANNELS; i++) begin
                r_duty[i] <= chan_res[i].duty;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_drive_bank_a = r_bank;
    assign o_drive_ch4    = r_d4;
    assign o_drive_ch5    = r_d5;
    assign o_duty_ch0     = r_duty[0];
    assign o_duty_ch1     = r_duty[1];
    assign o_duty_ch2     = r_duty[2];
    assign o_duty_ch3     = r_duty[3];
    assign o_duty_ch4     = r_duty[4];
    assign o_duty_ch5     = r_duty[5];

endmodule
